// ===== src/uifd_pkg.sv =====
// uifd_pkg: shared types, codes and helpers for the UI frame decoder.
// Depends on nothing; used by ui_frame_decoder.
`timescale 1ns / 1ps
`default_nettype none

package uifd_pkg;

    localparam int MAX_ADDRESSES_DEF  = 10;
    localparam int MAX_INFO_BYTES_DEF = 256;

    // two address fields plus control and pid
    localparam logic [8:0] MIN_FRAME_BYTES = 9'd16;
    localparam logic [8:0] BYTE_COUNT_MAX  = 9'd511;
    localparam logic [7:0] UI_CONTROL      = 8'h03;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_Z     = 7'h5A;
    localparam logic [6:0] CHAR_0     = 7'h30;
    localparam logic [6:0] CHAR_9     = 7'h39;

    // result kinds
    localparam logic [1:0] KIND_ADDRESS = 2'd0;
    localparam logic [1:0] KIND_PID     = 2'd1;
    localparam logic [1:0] KIND_INFO    = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    // status / error codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_BAD_CALL  = 2'd3;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  address_index;
        logic [41:0] callsign_chars;
        logic [2:0]  callsign_length;
        logic [3:0]  ssid;
        logic        repeated;
        logic        final_address;
        logic [7:0]  data_value;
        logic [1:0]  status;
        logic [8:0]  info_length;
        logic [3:0]  digipeater_count;
        logic        run_last;
    } result_t;

    function automatic logic legal_char(input logic [6:0] c);
        return ((c >= CHAR_A) && (c <= CHAR_Z)) || ((c >= CHAR_0) && (c <= CHAR_9));
    endfunction

endpackage

`default_nettype wire

// ===== src/ui_frame_decoder.sv =====
// A result word enters the result queue when its byte is accepted; m_ shows the queue head.
// Throughput: one byte per cycle while s_ready is high; a byte that yields two result
// words (data plus frame status) queues both, drained one a cycle while m_ready holds.
// Results pass through a four-word queue; s_ready holds while two words fit.
// Reset (aresetn low, synchronous) clears the frame state and empties the queue.
// ui_frame_decoder: streaming AX.25 UI frame decoder; uses uifd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ui_frame_decoder #(
    parameter int MAX_ADDRESSES  = uifd_pkg::MAX_ADDRESSES_DEF,
    parameter int MAX_INFO_BYTES = uifd_pkg::MAX_INFO_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_end_of_frame,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [3:0]       m_address_index,
    output logic [41:0]      m_callsign_chars,
    output logic [2:0]       m_callsign_length,
    output logic [3:0]       m_ssid,
    output logic             m_repeated,
    output logic             m_final_address,
    output logic [7:0]       m_data_value,
    output logic [1:0]       m_status,
    output logic [8:0]       m_info_length,
    output logic [3:0]       m_digipeater_count,
    output logic             m_run_last
);

    localparam int AW = $clog2(MAX_ADDRESSES + 1);
    localparam int IW = $clog2(MAX_INFO_BYTES + 2);
    localparam int PW = uifd_pkg::RES_PW;
    localparam int CW = uifd_pkg::RES_CW;

    typedef enum logic [1:0] {PH_ADDRESS, PH_CONTROL, PH_PID, PH_INFO} phase_t;

    phase_t          phase_reg, phase_next;
    logic [2:0]      bia_reg, bia_next;
    logic [AW-1:0]   addr_cnt_reg, addr_cnt_next;
    logic [41:0]     call_reg, call_next;
    logic [2:0]      char_cnt_reg, char_cnt_next;
    logic            pad_reg, pad_next;
    logic            pend_reg, pend_next;
    logic [1:0]      err_reg, err_next;
    logic [1:0]      bsa_reg, bsa_next;
    logic [8:0]      fbc_reg, fbc_next;
    logic [IW-1:0]   info_cnt_reg, info_cnt_next;

    uifd_pkg::result_t res_data, res_stat;
    logic              have_data;

    uifd_pkg::result_t fifo_reg [uifd_pkg::RES_DEPTH];
    logic [PW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [PW-1:0]     wr_ptr;
    logic              push, pop;

    assign s_ready = (count_reg <= CW'(uifd_pkg::RES_DEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign wr_ptr  = head_reg + count_reg[PW-1:0];

    // per-byte decode
    always_comb begin
        logic [6:0]    ch;
        logic [5:0]    shamt;
        logic          ext;
        logic [AW-1:0] idx;
        logic [IW-1:0] ilen;

        phase_next    = phase_reg;
        bia_next      = bia_reg;
        addr_cnt_next = addr_cnt_reg;
        call_next     = call_reg;
        char_cnt_next = char_cnt_reg;
        pad_next      = pad_reg;
        pend_next     = pend_reg;
        err_next      = err_reg;
        bsa_next      = bsa_reg;
        info_cnt_next = info_cnt_reg;
        fbc_next      = (fbc_reg < uifd_pkg::BYTE_COUNT_MAX) ? fbc_reg + 9'd1 : fbc_reg;

        ch    = s_frame_byte[7:1];
        shamt = 6'(7 * (3'd5 - char_cnt_reg));
        ext   = s_frame_byte[0];
        idx   = addr_cnt_reg;
        ilen  = '0;

        have_data = 1'b0;
        res_data  = '0;
        res_stat  = '0;

        if (err_reg != uifd_pkg::ST_OK) begin
            // suppressed until end of frame
        end else if (pend_reg && (bia_reg == 3'd0)) begin
            // bad callsign only counts once two more bytes have arrived
            bsa_next = bsa_reg + 2'd1;
            if (bsa_next >= 2'd2) begin
                err_next  = uifd_pkg::ST_BAD_CALL;
                pend_next = 1'b0;
            end
        end else begin
            unique case (phase_reg)
                PH_ADDRESS: begin
                    if ((bia_reg == 3'd0) && (addr_cnt_reg >= AW'(MAX_ADDRESSES))) begin
                        err_next = uifd_pkg::ST_MALFORMED;
                    end else if (bia_reg < 3'd6) begin
                        if (ch == uifd_pkg::CHAR_SPACE) begin
                            pad_next = 1'b1;
                        end else if (pad_reg || !uifd_pkg::legal_char(ch)) begin
                            pend_next = 1'b1;
                        end else if (char_cnt_reg < 3'd6) begin
                            call_next     = call_reg | ({35'd0, ch} << shamt);
                            char_cnt_next = char_cnt_reg + 3'd1;
                        end
                        bia_next = bia_reg + 3'd1;
                    end else begin
                        // SSID byte closes the address
                        if (char_cnt_reg == 3'd0)
                            pend_next = 1'b1;
                        bia_next = 3'd0;
                        if (pend_next) begin
                            bsa_next = 2'd0;
                        end else begin
                            addr_cnt_next = addr_cnt_reg + AW'(1);
                            if (ext && (idx == '0)) begin
                                err_next = uifd_pkg::ST_MALFORMED;
                            end else begin
                                have_data                = 1'b1;
                                res_data.kind            = uifd_pkg::KIND_ADDRESS;
                                res_data.address_index   = 4'(idx);
                                res_data.callsign_chars  = call_reg;
                                res_data.callsign_length = char_cnt_reg;
                                res_data.ssid            = s_frame_byte[4:1];
                                res_data.repeated        = s_frame_byte[7];
                                res_data.final_address   = ext;
                                if (ext)
                                    phase_next = PH_CONTROL;
                            end
                        end
                        call_next     = '0;
                        char_cnt_next = 3'd0;
                        pad_next      = 1'b0;
                    end
                end
                PH_CONTROL: begin
                    if (s_frame_byte != uifd_pkg::UI_CONTROL)
                        err_next = uifd_pkg::ST_MALFORMED;
                    else
                        phase_next = PH_PID;
                end
                PH_PID: begin
                    have_data           = 1'b1;
                    res_data.kind       = uifd_pkg::KIND_PID;
                    res_data.data_value = s_frame_byte;
                    phase_next          = PH_INFO;
                end
                PH_INFO: begin
                    if (info_cnt_reg >= IW'(MAX_INFO_BYTES)) begin
                        info_cnt_next = IW'(MAX_INFO_BYTES + 1);
                        err_next      = uifd_pkg::ST_BAD_LEN;
                    end else begin
                        info_cnt_next       = info_cnt_reg + IW'(1);
                        have_data           = 1'b1;
                        res_data.kind       = uifd_pkg::KIND_INFO;
                        res_data.data_value = s_frame_byte;
                    end
                end
                default: ;
            endcase
        end

        res_data.run_last = !s_end_of_frame;

        if (s_end_of_frame) begin
            ilen = (info_cnt_next > IW'(MAX_INFO_BYTES)) ? IW'(MAX_INFO_BYTES) : info_cnt_next;
            res_stat.kind     = uifd_pkg::KIND_STATUS;
            res_stat.run_last = 1'b1;
            priority if (fbc_next < uifd_pkg::MIN_FRAME_BYTES)
                res_stat.status = uifd_pkg::ST_BAD_LEN;
            else if (err_next != uifd_pkg::ST_OK)
                res_stat.status = err_next;
            else if (pend_next || (phase_next != PH_INFO))
                res_stat.status = uifd_pkg::ST_MALFORMED;
            else
                res_stat.status = uifd_pkg::ST_OK;
            res_stat.info_length      = 9'(ilen);
            res_stat.digipeater_count = (addr_cnt_next > AW'(2)) ?
                                        4'(addr_cnt_next - AW'(2)) : 4'd0;
            // frame state back to idle
            phase_next    = PH_ADDRESS;
            bia_next      = 3'd0;
            addr_cnt_next = '0;
            call_next     = '0;
            char_cnt_next = 3'd0;
            pad_next      = 1'b0;
            pend_next     = 1'b0;
            err_next      = uifd_pkg::ST_OK;
            bsa_next      = 2'd0;
            fbc_next      = 9'd0;
            info_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ADDRESS;
            bia_reg      <= 3'd0;
            addr_cnt_reg <= '0;
            call_reg     <= '0;
            char_cnt_reg <= 3'd0;
            pad_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            err_reg      <= uifd_pkg::ST_OK;
            bsa_reg      <= 2'd0;
            fbc_reg      <= 9'd0;
            info_cnt_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
        end else begin
            if (push) begin
                phase_reg    <= phase_next;
                bia_reg      <= bia_next;
                addr_cnt_reg <= addr_cnt_next;
                call_reg     <= call_next;
                char_cnt_reg <= char_cnt_next;
                pad_reg      <= pad_next;
                pend_reg     <= pend_next;
                err_reg      <= err_next;
                bsa_reg      <= bsa_next;
                fbc_reg      <= fbc_next;
                info_cnt_reg <= info_cnt_next;
            end
            if (pop)
                head_reg <= head_reg + PW'(1);
            count_reg <= count_reg
                         + CW'(push && have_data)
                         + CW'(push && s_end_of_frame)
                         - CW'(pop);
        end
        // queue words, no reset needed
        if (push) begin
            if (have_data) begin
                fifo_reg[wr_ptr] <= res_data;
                if (s_end_of_frame)
                    fifo_reg[wr_ptr + PW'(1)] <= res_stat;
            end else if (s_end_of_frame) begin
                fifo_reg[wr_ptr] <= res_stat;
            end
        end
    end

    assign m_kind             = fifo_reg[head_reg].kind;
    assign m_address_index    = fifo_reg[head_reg].address_index;
    assign m_callsign_chars   = fifo_reg[head_reg].callsign_chars;
    assign m_callsign_length  = fifo_reg[head_reg].callsign_length;
    assign m_ssid             = fifo_reg[head_reg].ssid;
    assign m_repeated         = fifo_reg[head_reg].repeated;
    assign m_final_address    = fifo_reg[head_reg].final_address;
    assign m_data_value       = fifo_reg[head_reg].data_value;
    assign m_status           = fifo_reg[head_reg].status;
    assign m_info_length      = fifo_reg[head_reg].info_length;
    assign m_digipeater_count = fifo_reg[head_reg].digipeater_count;
    assign m_run_last         = fifo_reg[head_reg].run_last;

endmodule

`default_nettype wire
